>>> rtl/pspc_pkg.sv
// Shared types and constants of the pedal sensor plausibility check.
// Used by the serial divider, the serial root, the top level and the checker.
`default_nettype none

package pspc_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int QUOT_BITS    = 7;
    localparam int ROOT_BITS    = 4;
    localparam int ROOT_IN_BITS = 7;
    localparam int PCT_W        = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_S1_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_S1_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_S2_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_S2_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_LIM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 3'd6;

    localparam int RST_S1_LOW  = 150;
    localparam int RST_S1_HIGH = 2150;
    localparam int RST_S2_LOW  = 155;
    localparam int RST_S2_HIGH = 2125;
    localparam logic [6:0]  RST_GAP_LIMIT  = 7'd10;
    localparam logic [7:0]  RST_STRIKE_LIM = 8'd2;
    localparam logic [15:0] RST_HOLD_TIME  = 16'd100;

    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF   = 7'd50;
    localparam logic [PCT_W-1:0] GAP_MAX    = 7'd127;
    localparam logic [7:0]       STRIKE_MAX = 8'hFF;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
        logic                 rem_nz;
    } t_div_res;

    typedef struct packed {
        logic                 done;
        logic [ROOT_BITS-1:0] root;
    } t_root_res;

endpackage

`default_nettype wire

>>> rtl/pspc_in_if.sv
// Input channel of the pedal sensor plausibility check: two samples and a time.
// Depends on pspc_pkg for the default sample width.
`default_nettype none

interface pspc_in_if #(
    parameter int ADC_BITS = pspc_pkg::ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] sensor1_sample;
    logic [ADC_BITS-1:0] sensor2_sample;
    logic [31:0]         now_ms;

    modport source (output valid, output sensor1_sample, output sensor2_sample,
                    output now_ms, input ready);
    modport sink (input valid, input sensor1_sample, input sensor2_sample,
                  input now_ms, output ready);
endinterface

`default_nettype wire

>>> rtl/pspc_out_if.sv
// Output channel of the pedal sensor plausibility check: pedal, gap and flag.
// Depends on nothing else.
`default_nettype none

interface pspc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] pedal_percent;
    logic [6:0] sensor_gap;
    logic       implausible;

    modport source (output valid, output pedal_percent, output sensor_gap,
                    output implausible, input ready);
    modport sink (input valid, input pedal_percent, input sensor_gap,
                  input implausible, output ready);
endinterface

`default_nettype wire

>>> rtl/pedal_sensor_plausibility_check_unit.sv
// Top level of the pedal sensor plausibility check: sequencer, state and registers.
// Depends on pspc_pkg, pspc_in_if, pspc_out_if, pspc_div and pspc_isqrt.
//
// A word on i_in carries two raw pedal sensor samples and a millisecond time.
// Each word yields exactly one word on o_out with the averaged pedal position,
// the corrected gap between the two sensors and the sticky implausible flag.
// A word is taken when i_in.valid and i_in.ready are both high; ready is high
// only while the sequencer is idle, so one word is in work at a time.
// After acceptance a word passes through ST_PREP, ST_DIV, ST_PED, ST_ROOT_GO,
// ST_ROOT, ST_GAP and ST_OUT, and the next word is taken once the sequencer
// is back in ST_IDLE. The seven-step quotient loop of the two dividers runs in
// ST_DIV and the four-step root loop runs in ST_ROOT.
// The result sits in an output register; while the receiver stalls, the next
// word is still accepted and processed, and it waits before its final step
// until the output register is free.
// Reset (synchronous, active low) loads the calibration defaults, clears the
// strike count, the last plausible time and the latch, and empties o_out.
// Configuration writes through i_cfg_we, i_cfg_index and i_cfg_data are taken
// in any cycle and belong in idle periods; unknown indexes are ignored.
`default_nettype none

module pedal_sensor_plausibility_check_unit #(
    parameter int ADC_BITS = pspc_pkg::ADC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    pspc_in_if.sink                            i_in,
    pspc_out_if.source                         o_out,
    input  wire                                i_cfg_we,
    input  wire [pspc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [pspc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int NW = ADC_BITS + pspc_pkg::QUOT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_DIV, ST_PED, ST_ROOT_GO, ST_ROOT, ST_GAP, ST_OUT
    } t_state;

    t_state r_state;

    logic [ADC_BITS-1:0] r_s1_low, r_s1_high, r_s2_low, r_s2_high;
    logic [6:0]          r_gap_limit;
    logic [7:0]          r_strike_lim;
    logic [15:0]         r_hold;

    logic [7:0]          r_strike;
    logic [31:0]         r_last;
    logic                r_latch;

    logic [ADC_BITS-1:0] r_c1, r_c2;
    logic [31:0]         r_now;
    logic [6:0]          r_p1, r_p2, r_pedal, r_gap;
    logic [pspc_pkg::ROOT_BITS-1:0] r_k;

    logic                r_out_valid;
    logic [6:0]          r_out_pedal, r_out_gap;
    logic                r_out_impl;

    logic [ADC_BITS-1:0] span1, span2, den1, den2;
    logic [NW-1:0]       num1, num2;
    logic                div_start, root_start;
    pspc_pkg::t_div_res  div1, div2;
    pspc_pkg::t_root_res root;
    logic [7:0]          pct_sum;
    logic [6:0]          m_val;
    logic [8:0]          five_m;
    logic signed [9:0]   diff;
    logic [9:0]          diff_abs;
    logic [7:0]          n_strike;
    logic [31:0]         elapsed;
    logic                out_free;

    function automatic logic [ADC_BITS-1:0] clamp_span(
        input logic [ADC_BITS-1:0] c,
        input logic [ADC_BITS-1:0] lo,
        input logic [ADC_BITS-1:0] hi
    );
        logic [ADC_BITS-1:0] res;
        if (c < lo) begin
            res = '0;
        end else if (c > hi) begin
            res = hi - lo;
        end else begin
            res = c - lo;
        end
        return res;
    endfunction

    assign span1 = clamp_span(r_c1, r_s1_low, r_s1_high);
    assign span2 = clamp_span(r_c2, r_s2_low, r_s2_high);
    assign den1  = r_s1_high - r_s1_low;
    assign den2  = r_s2_high - r_s2_low;
    assign num1  = (NW'(span1) << 6) + (NW'(span1) << 5) + (NW'(span1) << 2);
    assign num2  = (NW'(span2) << 6) + (NW'(span2) << 5) + (NW'(span2) << 2);

    assign div_start  = (r_state == ST_PREP);
    assign root_start = (r_state == ST_ROOT_GO);

    pspc_div #(.ADC_BITS(ADC_BITS)) u_div1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num1), .i_den(den1), .o_res(div1)
    );

    pspc_div #(.ADC_BITS(ADC_BITS)) u_div2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num2), .i_den(den2), .o_res(div2)
    );

    assign pct_sum = {1'b0, r_p1} + {1'b0, r_p2};
    assign m_val   = (r_pedal < pspc_pkg::PCT_HALF) ? r_pedal
                                                    : (pspc_pkg::PCT_FULL - r_pedal);
    assign five_m  = {m_val, 2'b00} + {2'b00, m_val};

    pspc_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(root_start),
        .i_val(five_m[7:1]), .o_res(root)
    );

    assign diff     = $signed({3'b000, r_p1}) + $signed({5'b00000, r_k, 1'b0})
                    - $signed({3'b000, r_p2});
    assign diff_abs = diff[9] ? 10'(-diff) : 10'(diff);
    assign n_strike = (r_strike == pspc_pkg::STRIKE_MAX) ? r_strike : r_strike + 8'd1;
    assign elapsed  = r_now - r_last;
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_low     <= ADC_BITS'(pspc_pkg::RST_S1_LOW);
            r_s1_high    <= ADC_BITS'(pspc_pkg::RST_S1_HIGH);
            r_s2_low     <= ADC_BITS'(pspc_pkg::RST_S2_LOW);
            r_s2_high    <= ADC_BITS'(pspc_pkg::RST_S2_HIGH);
            r_gap_limit  <= pspc_pkg::RST_GAP_LIMIT;
            r_strike_lim <= pspc_pkg::RST_STRIKE_LIM;
            r_hold       <= pspc_pkg::RST_HOLD_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pspc_pkg::CFG_S1_LOW:     r_s1_low     <= i_cfg_data[ADC_BITS-1:0];
                pspc_pkg::CFG_S1_HIGH:    r_s1_high    <= i_cfg_data[ADC_BITS-1:0];
                pspc_pkg::CFG_S2_LOW:     r_s2_low     <= i_cfg_data[ADC_BITS-1:0];
                pspc_pkg::CFG_S2_HIGH:    r_s2_high    <= i_cfg_data[ADC_BITS-1:0];
                pspc_pkg::CFG_GAP_LIMIT:  r_gap_limit  <= i_cfg_data[6:0];
                pspc_pkg::CFG_STRIKE_LIM: r_strike_lim <= i_cfg_data[7:0];
                pspc_pkg::CFG_HOLD_TIME:  r_hold       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_strike    <= '0;
            r_last      <= '0;
            r_latch     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_c1    <= i_in.sensor1_sample;
                        r_c2    <= i_in.sensor2_sample;
                        r_now   <= i_in.now_ms;
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div1.done) begin
                        r_p1 <= (r_s1_high > r_s1_low)
                              ? pspc_pkg::PCT_FULL - (div1.quot + 7'(div1.rem_nz)) : '0;
                        r_p2 <= (r_s2_high > r_s2_low) ? div2.quot : '0;
                        r_state <= ST_PED;
                    end
                end
                ST_PED: begin
                    r_pedal <= pct_sum[7:1];
                    r_state <= ST_ROOT_GO;
                end
                ST_ROOT_GO: begin
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (root.done) begin
                        r_k     <= root.root;
                        r_state <= ST_GAP;
                    end
                end
                ST_GAP: begin
                    r_gap   <= (diff_abs > 10'(pspc_pkg::GAP_MAX)) ? pspc_pkg::GAP_MAX
                                                               : diff_abs[6:0];
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        if (r_gap > r_gap_limit) begin
                            r_strike <= n_strike;
                            if (n_strike > r_strike_lim && elapsed > 32'(r_hold)) begin
                                r_latch <= 1'b1;
                            end
                            r_out_impl <= r_latch
                                | (n_strike > r_strike_lim && elapsed > 32'(r_hold));
                        end else begin
                            r_strike   <= '0;
                            r_last     <= r_now;
                            r_out_impl <= r_latch;
                        end
                        r_out_pedal <= r_pedal;
                        r_out_gap   <= r_gap;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.pedal_percent = r_out_pedal;
    assign o_out.sensor_gap    = r_out_gap;
    assign o_out.implausible   = r_out_impl;
endmodule

`default_nettype wire

>>> rtl/pspc_div.sv
// Restoring divider that yields one quotient bit per cycle, seven bits in all.
// Depends on pspc_pkg for the result struct.
`default_nettype none

module pspc_div #(
    parameter int ADC_BITS = pspc_pkg::ADC_BITS_DEF
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire                                        i_start,
    input  wire [ADC_BITS+pspc_pkg::QUOT_BITS-1:0]     i_num,
    input  wire [ADC_BITS-1:0]                         i_den,
    output pspc_pkg::t_div_res                         o_res
);
    localparam int NW = ADC_BITS + pspc_pkg::QUOT_BITS;
    localparam int CW = $clog2(pspc_pkg::QUOT_BITS + 1);

    logic [NW-1:0]                    r_rem;
    logic [NW-1:0]                    r_dsh;
    logic [pspc_pkg::QUOT_BITS-1:0]   r_quot;
    logic [CW-1:0]                    r_cnt;
    logic                             r_busy;
    logic                             r_done;
    logic                             ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_dsh  <= NW'(i_den) << (pspc_pkg::QUOT_BITS - 1);
                r_quot <= '0;
                r_cnt  <= CW'(pspc_pkg::QUOT_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quot <= {r_quot[pspc_pkg::QUOT_BITS-2:0], ge};
                r_dsh  <= r_dsh >> 1;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quot   = r_quot;
    assign o_res.rem_nz = (r_rem != '0);
endmodule

`default_nettype wire

>>> rtl/pspc_isqrt.sv
// Integer square root that settles one result bit per cycle, four bits in all.
// Depends on pspc_pkg for widths and the result struct.
`default_nettype none

module pspc_isqrt (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_start,
    input  wire [pspc_pkg::ROOT_IN_BITS-1:0]     i_val,
    output pspc_pkg::t_root_res                  o_res
);
    localparam int RB = pspc_pkg::ROOT_BITS;

    logic [pspc_pkg::ROOT_IN_BITS-1:0] r_val;
    logic [RB-1:0]                     r_root;
    logic [RB-1:0]                     r_bit;
    logic                              r_done;
    logic [RB-1:0]                     trial;
    logic [2*RB-1:0]                   sq;

    assign trial = r_root | r_bit;
    assign sq    = (2*RB)'(trial) * (2*RB)'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_val  <= i_val;
                r_root <= '0;
                r_bit  <= RB'(1) << (RB - 1);
            end else if (r_bit != '0) begin
                if (sq <= (2*RB)'(r_val)) begin
                    r_root <= trial;
                end
                r_bit <= r_bit >> 1;
                if (r_bit == RB'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.root = r_root;
endmodule

`default_nettype wire

>>> rtl/pspc_checker.sv
// Port-level checker of the pedal sensor plausibility check, bound to the top level.
// Depends on pspc_pkg and on the ports of pedal_sensor_plausibility_check_unit.
`default_nettype none

module pspc_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [6:0] i_pedal_percent,
    input wire [6:0] i_sensor_gap,
    input wire       i_implausible
);
    logic [1:0] r_pend;
    logic       r_impl_seen;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_impl_seen <= 1'b0;
        end else begin
            r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
            if (out_acc && i_implausible) begin
                r_impl_seen <= 1'b1;
            end
        end
    end

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pedal_percent)
            && $stable(i_sensor_gap) && $stable(i_implausible))
        else $error("output word changed while stalled");

    a_pedal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_pedal_percent <= pspc_pkg::PCT_FULL)
        else $error("pedal percent above full scale");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("output word without an accepted input word");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> r_pend <= 2'd1)
        else $error("input accepted while another word is still in work");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_impl_seen |-> i_implausible)
        else $error("implausible flag dropped after being reported");
endmodule

bind pedal_sensor_plausibility_check_unit pspc_checker u_pspc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_pedal_percent(o_out.pedal_percent),
    .i_sensor_gap   (o_out.sensor_gap),
    .i_implausible  (o_out.implausible)
);

`default_nettype wire

>>> test/pedal_sensor_plausibility_check_unit_tb.sv
// Self-checking testbench of the pedal sensor plausibility check unit.
// Depends on pspc_pkg, pspc_in_if, pspc_out_if and pedal_sensor_plausibility_check_unit.
// Directed and random sample words are predicted as they are accepted and checked field by field.

module pedal_sensor_plausibility_check_unit_tb;

    localparam int AW = pspc_pkg::ADC_BITS_DEF;
    localparam int ADC_MAX = (1 << AW) - 1;
    localparam logic [pspc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int FREE_RUN_FROM = 700;
    localparam int FREE_RUN_TO   = 900;
    localparam int BACKUP_AT     = 1000;
    localparam int BACKUP_CYCLES = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic {READ_TIDY, READ_NOISE} t_reading_kind;

    typedef struct packed {
        logic [AW-1:0] sensor1_sample;
        logic [AW-1:0] sensor2_sample;
        logic [31:0]   now_ms;
    } t_pedal_sample;

    typedef struct packed {
        logic [pspc_pkg::PCT_W-1:0] pedal_percent;
        logic [pspc_pkg::PCT_W-1:0] sensor_gap;
        logic                       implausible;
    } t_pedal_verdict;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [pspc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pspc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [AW-1:0]   cal1_lo = pspc_pkg::RST_S1_LOW;
    logic [AW-1:0]   cal1_hi = pspc_pkg::RST_S1_HIGH;
    logic [AW-1:0]   cal2_lo = pspc_pkg::RST_S2_LOW;
    logic [AW-1:0]   cal2_hi = pspc_pkg::RST_S2_HIGH;
    logic [6:0]      gap_lim = pspc_pkg::RST_GAP_LIMIT;
    logic [7:0]      strike_lim = pspc_pkg::RST_STRIKE_LIM;
    logic [15:0]     hold_ms = pspc_pkg::RST_HOLD_TIME;

    logic [7:0]  strikes = '0;
    logic [31:0] last_ok_ms = '0;
    logic        latched = 1'b0;

    t_pedal_sample  pending[$];
    t_pedal_verdict results_due[$];
    logic [31:0]    clock_ms = '0;
    int             words_in = 0;
    int             words_out = 0;
    int             n_errors = 0;
    int             stall_left = 0;
    logic           backed_up = 1'b0;
    int             quiet_cycles = 0;

    pspc_in_if  in_if ();
    pspc_out_if out_if ();

    pedal_sensor_plausibility_check_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned sensor_pct(input int unsigned smp, input int unsigned lo,
                                               input int unsigned hi, input bit inverse);
        int unsigned den;
        int unsigned span;
        if (hi <= lo) return 0;
        den = hi - lo;
        span = (smp < lo) ? 0 : (smp > hi) ? den : smp - lo;
        if (inverse) return 100 - (100 * span + den - 1) / den;
        return (100 * span) / den;
    endfunction

    function automatic int unsigned pedal_correction(input int unsigned pedal);
        int unsigned m;
        int unsigned v;
        int unsigned r;
        m = (pedal < pspc_pkg::PCT_HALF) ? pedal : pspc_pkg::PCT_FULL - pedal;
        v = (5 * m) / 2;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    // Updates the strike count, the last plausible time and the latch.
    function automatic t_pedal_verdict judge_pedal(input logic [AW-1:0] s1,
                                                   input logic [AW-1:0] s2,
                                                   input logic [31:0] now);
        int unsigned p1;
        int unsigned p2;
        int unsigned pedal;
        int unsigned k;
        int          diff;
        int unsigned gap;
        logic [31:0] elapsed;
        t_pedal_verdict v;
        p1 = sensor_pct(s1, cal1_lo, cal1_hi, 1'b1);
        p2 = sensor_pct(s2, cal2_lo, cal2_hi, 1'b0);
        pedal = (p1 + p2) / 2;
        k = pedal_correction(pedal);
        diff = int'(p1) + 2 * int'(k) - int'(p2);
        gap = (diff < 0) ? -diff : diff;
        if (gap > pspc_pkg::GAP_MAX) gap = pspc_pkg::GAP_MAX;
        if (gap > gap_lim) begin
            if (strikes != pspc_pkg::STRIKE_MAX) strikes = strikes + 8'd1;
            elapsed = now - last_ok_ms;
            if (strikes > strike_lim && elapsed > hold_ms) latched = 1'b1;
        end else begin
            strikes = '0;
            last_ok_ms = now;
        end
        v.pedal_percent = pedal[pspc_pkg::PCT_W-1:0];
        v.sensor_gap = gap[pspc_pkg::PCT_W-1:0];
        v.implausible = latched;
        return v;
    endfunction

    function automatic logic [31:0] next_step_ms();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 4) return $urandom();
        if (r < 10) return '0;
        return $urandom_range(30, 1);
    endfunction

    task automatic offer(input logic [AW-1:0] s1, input logic [AW-1:0] s2,
                         input logic [31:0] now);
        pending.push_back('{s1, s2, now});
        clock_ms = now;
    endtask

    // A tidy reading puts sensor two where the corrected gap stays small.
    task automatic queue_reading(input t_reading_kind kind, input logic [31:0] step);
        int unsigned s1;
        int unsigned s2;
        int unsigned p1;
        int unsigned k;
        int unsigned target;
        int unsigned j;
        int          s2_pos;
        s1 = $urandom_range(ADC_MAX, 0);
        s2 = $urandom_range(ADC_MAX, 0);
        if (kind == READ_TIDY) begin
            if (cal1_hi > cal1_lo && $urandom_range(99, 0) >= 10)
                s1 = $urandom_range(cal1_hi, cal1_lo);
            p1 = sensor_pct(s1, cal1_lo, cal1_hi, 1'b1);
            k = pedal_correction(p1);
            k = pedal_correction((p1 + k > 100) ? 100 : p1 + k);
            target = (p1 + 2 * k > 100) ? 100 : p1 + 2 * k;
            if (cal2_hi > cal2_lo) begin
                j = (cal2_hi - cal2_lo) / 40 + 1;
                s2_pos = int'(cal2_lo + target * (cal2_hi - cal2_lo) / 100
                              + $urandom_range(2 * j, 0)) - int'(j);
                s2 = (s2_pos < 0) ? 0 : (s2_pos > ADC_MAX) ? ADC_MAX : s2_pos;
            end
        end
        offer(s1, s2, clock_ms + step);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending.size() != 0 || in_if.valid || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pspc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pspc_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            pspc_pkg::CFG_S1_LOW:     cal1_lo = data[AW-1:0];
            pspc_pkg::CFG_S1_HIGH:    cal1_hi = data[AW-1:0];
            pspc_pkg::CFG_S2_LOW:     cal2_lo = data[AW-1:0];
            pspc_pkg::CFG_S2_HIGH:    cal2_hi = data[AW-1:0];
            pspc_pkg::CFG_GAP_LIMIT:  gap_lim = data[6:0];
            pspc_pkg::CFG_STRIKE_LIM: strike_lim = data[7:0];
            pspc_pkg::CFG_HOLD_TIME:  hold_ms = data;
            default: ;
        endcase
    endtask

    task automatic calibrate(input logic [pspc_pkg::CFG_DATA_W-1:0] lo1,
                             input logic [pspc_pkg::CFG_DATA_W-1:0] hi1,
                             input logic [pspc_pkg::CFG_DATA_W-1:0] lo2,
                             input logic [pspc_pkg::CFG_DATA_W-1:0] hi2,
                             input logic [pspc_pkg::CFG_DATA_W-1:0] gap,
                             input logic [pspc_pkg::CFG_DATA_W-1:0] lim,
                             input logic [pspc_pkg::CFG_DATA_W-1:0] hold);
        write_reg(pspc_pkg::CFG_S1_LOW, lo1);
        write_reg(pspc_pkg::CFG_S1_HIGH, hi1);
        write_reg(pspc_pkg::CFG_S2_LOW, lo2);
        write_reg(pspc_pkg::CFG_S2_HIGH, hi2);
        write_reg(pspc_pkg::CFG_GAP_LIMIT, gap);
        write_reg(pspc_pkg::CFG_STRIKE_LIM, lim);
        write_reg(pspc_pkg::CFG_HOLD_TIME, hold);
    endtask

    task automatic run_readings(input int count, input int noise_pct);
        repeat (count)
            queue_reading(($urandom_range(99, 0) < noise_pct) ? READ_NOISE : READ_TIDY,
                          next_step_ms());
        drain();
    endtask

    always @(posedge i_clk) begin : drive
        t_pedal_sample nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                results_due.push_back(judge_pedal(in_if.sensor1_sample, in_if.sensor2_sample,
                                                  in_if.now_ms));
                words_in <= words_in + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending.size() != 0 && ((words_in >= FREE_RUN_FROM && words_in < FREE_RUN_TO)
                                            || $urandom_range(99, 0) >= 25)) begin
                    nxt = pending.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.sensor1_sample <= nxt.sensor1_sample;
                    in_if.sensor2_sample <= nxt.sensor2_sample;
                    in_if.now_ms <= nxt.now_ms;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_pedal_verdict want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                words_out <= words_out + 1;
                if (results_due.size() == 0) begin
                    $error("result word arrived with no prediction pending");
                    n_errors++;
                end else begin
                    want = results_due.pop_front();
                    if (out_if.pedal_percent !== want.pedal_percent) begin
                        $error("pedal_percent: expected %0d, got %0d",
                               want.pedal_percent, out_if.pedal_percent);
                        n_errors++;
                    end
                    if (out_if.sensor_gap !== want.sensor_gap) begin
                        $error("sensor_gap: expected %0d, got %0d",
                               want.sensor_gap, out_if.sensor_gap);
                        n_errors++;
                    end
                    if (out_if.implausible !== want.implausible) begin
                        $error("implausible: expected %0d, got %0d",
                               want.implausible, out_if.implausible);
                        n_errors++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_if.ready <= 1'b0;
            end else if (words_out == BACKUP_AT && !backed_up) begin
                stall_left <= BACKUP_CYCLES;
                backed_up <= 1'b1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= (words_out >= FREE_RUN_FROM && words_out < FREE_RUN_TO)
                                || $urandom_range(99, 0) >= 25;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned lo1;
        int unsigned lo2;
        int          n;
        int          burst;
        in_if.valid = 1'b0;
        in_if.sensor1_sample = '0;
        in_if.sensor2_sample = '0;
        in_if.now_ms = '0;
        out_if.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Clamping, rounding and the wrap of the time; the hold time is never exceeded here.
        offer(12'd0, 12'd0, 32'h0000_0000);
        offer(12'hFFF, 12'hFFF, 32'h0000_000A);
        offer(12'd150, 12'd155, 32'h0000_0014);
        offer(12'd2150, 12'd2125, 32'h0000_001E);
        offer(12'd2150, 12'd155, 32'hFFFF_FFF0);
        offer(12'hFFF, 12'd0, 32'hFFFF_FFFF);
        offer(12'd0, 12'd0, 32'h0000_0010);
        offer(12'hFFF, 12'hFFF, 32'h0000_0030);
        offer(12'd150, 12'd155, 32'h0000_0050);
        offer(12'd0, 12'd0, 32'h0000_0063);
        offer(12'd151, 12'd2124, 32'h0000_0064);
        offer(12'd1150, 12'd1140, 32'h0000_0070);
        offer(12'd1149, 12'd1141, 32'h0000_0080);
        offer(12'd1170, 12'd1160, 32'h0000_0090);
        offer(12'd150, 12'd2125, 32'h0000_00A0);
        offer(12'd2149, 12'd156, 32'h0000_00B0);
        offer(12'd1650, 12'd1633, 32'h0000_00C0);
        offer(12'd0, 12'hFFF, 32'hFFFF_0000);
        drain();

        calibrate(16'hFFFF, 16'h0000, 16'h0000, 16'h0FFF, 16'h0000, 16'h00FF, 16'h0000);
        run_readings(60, 15);

        calibrate(16'h0000, 16'h0FFF, 16'h0000, 16'h0FFF, 16'h007F, 16'h0000, 16'hFFFF);
        run_readings(200, 15);

        lo1 = $urandom_range(2000, 0);
        lo2 = $urandom_range(2000, 0);
        calibrate({4'($urandom_range(15, 1)), 12'(lo1)},
                  {4'($urandom_range(15, 1)), 12'($urandom_range(ADC_MAX, lo1 + 1))},
                  {4'($urandom_range(15, 1)), 12'(lo2)},
                  {4'($urandom_range(15, 1)), 12'($urandom_range(ADC_MAX, lo2 + 1))},
                  {9'($urandom()), 7'($urandom_range(30, 0))},
                  {8'($urandom()), 8'hFF},
                  16'($urandom()));
        write_reg(CFG_UNUSED, 16'($urandom()));
        run_readings(400, 15);

        calibrate(16'h0FFE, 16'h0FFF, 16'h0800, 16'h0800, 16'($urandom_range(5, 0)),
                  16'h00FF, 16'h0000);
        run_readings(200, 20);

        // Back to the usual calibration; bursts of bad words let the latch set.
        calibrate(16'(pspc_pkg::RST_S1_LOW), 16'(pspc_pkg::RST_S1_HIGH),
                  16'(pspc_pkg::RST_S2_LOW), 16'(pspc_pkg::RST_S2_HIGH),
                  16'(pspc_pkg::RST_GAP_LIMIT), 16'(pspc_pkg::RST_STRIKE_LIM),
                  16'(pspc_pkg::RST_HOLD_TIME));
        n = 0;
        while (n < 570) begin
            if ($urandom_range(99, 0) < 6) begin
                burst = $urandom_range(8, 3);
                repeat (burst) queue_reading(READ_NOISE, $urandom_range(60, 15));
                n += burst;
            end else begin
                queue_reading(READ_TIDY, next_step_ms());
                n++;
            end
        end
        drain();

        if (n_errors == 0 && results_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
